### hdl/adc_round_robin_block_averager_unit_assert.svh
// assertion macros for the round-robin block averager
`ifndef ADC_ROUND_ROBIN_BLOCK_AVERAGER_UNIT_ASSERT_SVH
`define ADC_ROUND_ROBIN_BLOCK_AVERAGER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ARRBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ARRBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/arrba_pkg.sv
// shared types and constants for the round-robin block averager
`default_nettype none

package arrba_pkg;

  localparam int SAMPLES_DEF     = 16;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int IN_W            = 12;
  localparam int MEAN_W          = 12;
  localparam int NUM_CH          = 4;
  localparam int CH_W            = 2;
  localparam int S_TDATA_W       = 16;
  localparam int M_TDATA_W       = 56;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_CH0   = 5'b00010,
    PH_CH1   = 5'b00100,
    PH_CH2   = 5'b01000,
    PH_CH3   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic            take;
    logic [CH_W-1:0] chan;
    logic            latch;
  } accum_ctrl_t;

endpackage

`default_nettype wire

### hdl/arrba_accum.sv
// per-channel running sums and latched block means
`default_nettype none

module arrba_accum #(
  parameter int SAMPLES     = arrba_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = arrba_pkg::SAMPLE_BITS_DEF,
  localparam int LOG2_N     = $clog2(SAMPLES),
  localparam int SUM_W      = SAMPLE_BITS + LOG2_N
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst,
  input  wire arrba_pkg::accum_ctrl_t                           ctrl,
  input  wire logic [SUM_W-1:0]                                 sample_ext,
  output logic [arrba_pkg::NUM_CH-1:0][arrba_pkg::MEAN_W-1:0]   means
);

  localparam int EXT_W = (SUM_W > arrba_pkg::MEAN_W) ? SUM_W : arrba_pkg::MEAN_W;

  logic [arrba_pkg::NUM_CH-1:0][SUM_W-1:0]            sums;
  logic [arrba_pkg::NUM_CH-1:0][SUM_W-1:0]            sums_next;
  logic [arrba_pkg::NUM_CH-1:0][arrba_pkg::MEAN_W-1:0] means_next;
  logic [EXT_W-1:0]                                   shifted;

  always_comb begin
    shifted = '0;
    for (int c = 0; c < arrba_pkg::NUM_CH; c++) begin
      sums_next[c] = sums[c];
      if (ctrl.take && (ctrl.chan == arrba_pkg::CH_W'(c))) begin
        sums_next[c] = sums[c] + sample_ext;
      end
      shifted       = EXT_W'(sums_next[c]) >> LOG2_N;
      means_next[c] = shifted[arrba_pkg::MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums  <= '0;
      means <= '0;
    end else if (ctrl.latch) begin
      sums  <= '0;
      means <= means_next;
    end else begin
      sums  <= sums_next;
    end
  end

endmodule

`default_nettype wire

### hdl/adc_round_robin_block_averager_unit.sv
// a result word is registered and appears in the cycle after its sample word is taken
// throughput: one sample word per cycle; input stalls only while the output holds
// an untaken word
// averages are latched every SAMPLES five-word rounds (SAMPLES must be a power of two)
// synchronous reset: sequencer to phase 0, round count, sums and means to zero, output valid cleared
`default_nettype none

`include "adc_round_robin_block_averager_unit_assert.svh"

module adc_round_robin_block_averager_unit #(
  parameter int SAMPLES     = arrba_pkg::SAMPLES_DEF,
  parameter int SAMPLE_BITS = arrba_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // sample[11:0], zero fill above
  input  wire logic [arrba_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // start_conversion[0], convert_channel[2:1], sample_taken[3], averages_ready[4],
  // mean_ch0[16:5], mean_ch1[28:17], mean_ch2[40:29], mean_ch3[52:41], zero fill above
  output logic [arrba_pkg::M_TDATA_W-1:0]         m_tdata
);

  localparam int LOG2_N = $clog2(SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + LOG2_N;
  localparam int RC_W   = LOG2_N;
  localparam int USE_W  = (SAMPLE_BITS < arrba_pkg::IN_W) ? SAMPLE_BITS : arrba_pkg::IN_W;

  arrba_pkg::phase_t      phase, phase_next;
  logic [RC_W-1:0]        round_count, round_count_next;
  arrba_pkg::accum_ctrl_t ctrl;
  logic                   accept;
  logic [SUM_W-1:0]       sample_ext;

  logic                       start_next, taken_next, ready_next;
  logic [arrba_pkg::CH_W-1:0] chan_next;
  logic                       start_conversion, sample_taken, averages_ready;
  logic [arrba_pkg::CH_W-1:0] convert_channel;

  logic [arrba_pkg::NUM_CH-1:0][arrba_pkg::MEAN_W-1:0] means;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign sample_ext = SUM_W'(s_tdata[USE_W-1:0]);

  always_comb begin
    phase_next       = phase;
    round_count_next = round_count;
    start_next       = 1'b0;
    chan_next        = '0;
    taken_next       = 1'b0;
    ready_next       = 1'b0;
    unique case (phase)
      arrba_pkg::PH_CH0: begin
        taken_next = 1'b1;
        start_next = 1'b1;
        chan_next  = arrba_pkg::CH_W'(1);
        phase_next = arrba_pkg::PH_CH1;
      end
      arrba_pkg::PH_CH1: begin
        taken_next = 1'b1;
        start_next = 1'b1;
        chan_next  = arrba_pkg::CH_W'(2);
        phase_next = arrba_pkg::PH_CH2;
      end
      arrba_pkg::PH_CH2: begin
        taken_next = 1'b1;
        start_next = 1'b1;
        chan_next  = arrba_pkg::CH_W'(3);
        phase_next = arrba_pkg::PH_CH3;
      end
      arrba_pkg::PH_CH3: begin
        taken_next = 1'b1;
        phase_next = arrba_pkg::PH_START;
        if (round_count == RC_W'(SAMPLES - 1)) begin
          round_count_next = '0;
          ready_next       = 1'b1;
        end else begin
          round_count_next = round_count + RC_W'(1);
        end
      end
      default: begin
        start_next = 1'b1;
        phase_next = arrba_pkg::PH_CH0;
      end
    endcase
  end

  // sample in phase n+1 belongs to channel n
  always_comb begin
    ctrl.take  = accept && taken_next;
    ctrl.latch = accept && ready_next;
    unique case (phase)
      arrba_pkg::PH_CH1: ctrl.chan = arrba_pkg::CH_W'(1);
      arrba_pkg::PH_CH2: ctrl.chan = arrba_pkg::CH_W'(2);
      arrba_pkg::PH_CH3: ctrl.chan = arrba_pkg::CH_W'(3);
      default:           ctrl.chan = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= arrba_pkg::PH_START;
      round_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        round_count <= round_count_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_conversion <= start_next;
      convert_channel  <= chan_next;
      sample_taken     <= taken_next;
      averages_ready   <= ready_next;
    end
  end

  arrba_accum #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_ext (sample_ext),
    .means      (means)
  );

  assign m_tdata = {3'b000, means[3], means[2], means[1], means[0],
                    averages_ready, sample_taken, convert_channel, start_conversion};

  `ARRBA_ASSERT_NOW(a_stall_needs_word, !s_tready, m_tvalid, "input stalled with no word held")
  `ARRBA_ASSERT_NEXT(a_start_phase, accept && (phase == arrba_pkg::PH_START), m_tvalid && start_conversion && !sample_taken && (convert_channel == '0), "phase 0 word wrong")
  `ARRBA_ASSERT_NEXT(a_round_end, accept && (phase == arrba_pkg::PH_CH3) && (round_count == RC_W'(SAMPLES - 1)), m_tvalid && averages_ready && (round_count == '0), "block end not flagged")
  `ARRBA_ASSERT_NEXT(a_ready_only_ch3, accept && (phase != arrba_pkg::PH_CH3), !averages_ready, "means latched outside last phase")

endmodule

`default_nettype wire
